// ===== design/assert_macros.svh =====
// Assertion macros shared by the clipper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition in one cycle leads to a result in the next.
`define PLC_ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== design/plc_pkg.sv =====
// Shared constants and types of the polygon plane clipper.
package plc_pkg;

  localparam int MAX_VERTS   = 32;
  localparam int IDX_W       = $clog2(MAX_VERTS);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int COORD_W     = 32;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SHIFT_W     = PROD_W - 16;
  localparam int DIST_W      = 50;
  localparam int FRAC_W      = COORD_W + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CFG_PLANE_A = 2'd0;
  localparam logic [1:0] CFG_PLANE_B = 2'd1;
  localparam logic [1:0] CFG_PLANE_C = 2'd2;
  localparam logic [1:0] CFG_PLANE_D = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_ORIGINAL = 2'd0;
  localparam status_t STATUS_CLIPPED  = 2'd1;
  localparam status_t STATUS_VANISHED = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [DIST_W-1:0]  sdist;
    logic                      last;
  } vert_entry_t;

endpackage

// ===== design/polygon_plane_clip.sv =====
// Top level of the single-plane polygon clipper.
//
// Clips one polygon against the plane a*x + b*y + c*z + d (all Q16.16), one
// vertex per input beat; the beat with final_vertex set closes the polygon.
// A vertex is inside when its distance is not below zero. The front end takes
// a vertex only while idle, runs it through a single 32x32 multiplier that
// forms the three products and sums them with d, and pushes it into a
// two-entry queue. The back end stores each queued vertex and, on the closing
// vertex, walks the edges starting with the closing edge from the last vertex
// to the first. An edge with both ends inside is read, evaluated and sent as
// one output beat; an edge that crosses the plane adds a restoring divider
// for the crossing fraction and interpolation through one 32x33 multiplier;
// an edge fully outside is read, evaluated and skipped. Results leave through
// an output register, so the back end keeps working while a beat waits, and
// the front end takes vertices of the next polygon until the queue is full
// while the back end clips. Every beat carries clip_status (original, or
// clipped if any vertex lay outside), overflowed (vertices beyond 32 were
// dropped) and end_of_run on the last beat of the polygon. A polygon with
// nothing left gives one beat with vertex_valid low and status vanished.
// Write the plane registers only while the block is idle.
module polygon_plane_clip (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  input  logic               final_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ox,
  output logic signed [31:0] oy,
  output logic signed [31:0] oz,
  output logic               vertex_valid,
  output logic [1:0]         clip_status,
  output logic               overflowed,
  output logic               end_of_run
);
  import plc_pkg::*;

  vert_entry_t push_entry, pop_entry;
  logic        push, full, pop, not_empty;

  // Intake and distance.
  plc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vx           (vx),
    .vy           (vy),
    .vz           (vz),
    .final_vertex (final_vertex),
    .q_push       (push),
    .q_entry      (push_entry),
    .q_full       (full)
  );

  // Decouple intake from the edge walk.
  plc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .not_empty  (not_empty)
  );

  // Store, walk and emit.
  plc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (not_empty),
    .q_entry      (pop_entry),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ox           (ox),
    .oy           (oy),
    .oz           (oz),
    .vertex_valid (vertex_valid),
    .clip_status  (clip_status),
    .overflowed   (overflowed),
    .end_of_run   (end_of_run)
  );

endmodule

// ===== design/plc_front.sv =====
// Front end: plane registers, vertex intake and plane distance.
module plc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          vx,
  input  logic signed [31:0]          vy,
  input  logic signed [31:0]          vz,
  input  logic                        final_vertex,
  output logic                        q_push,
  output plc_pkg::vert_entry_t        q_entry,
  input  logic                        q_full
);
  import plc_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t              state;
  logic [1:0]                step;
  logic signed [COORD_W-1:0] plane_a, plane_b, plane_c, plane_d;
  logic signed [COORD_W-1:0] x, y, z;
  logic                      last;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIST_W-1:0]  acc;
  logic signed [COORD_W-1:0] coef_sel, coord_sel;
  logic signed [PROD_W-1:0]  mul_full;
  logic signed [SHIFT_W-1:0] prod_sh;
  logic                      accept;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign q_push   = (state == F_PUSH) & ~q_full;
  assign q_entry  = '{x: x, y: y, z: z, sdist: acc, last: last};

  always_comb begin
    case (step)
      2'd0:    begin coef_sel = plane_a; coord_sel = x; end
      2'd1:    begin coef_sel = plane_b; coord_sel = y; end
      default: begin coef_sel = plane_c; coord_sel = z; end
    endcase
  end

  assign mul_full = coef_sel * coord_sel;
  // Floor shift by 16 of the exact product.
  assign prod_sh  = prod[PROD_W-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      step    <= 2'd0;
      plane_a <= '0;
      plane_b <= '0;
      plane_c <= '0;
      plane_d <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PLANE_A: plane_a <= cfg_data;
          CFG_PLANE_B: plane_b <= cfg_data;
          CFG_PLANE_C: plane_c <= cfg_data;
          CFG_PLANE_D: plane_d <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            x     <= vx;
            y     <= vy;
            z     <= vz;
            last  <= final_vertex;
            step  <= 2'd0;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          prod <= mul_full;
          step <= step + 2'd1;
          if (step == 2'd1) begin
            acc <= DIST_W'(plane_d) + DIST_W'(prod_sh);
          end else if (step != 2'd0) begin
            acc <= acc + DIST_W'(prod_sh);
          end
          if (step == 2'd3) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/plc_queue.sv =====
// Short queue of classified vertices between front and back.
`include "assert_macros.svh"

module plc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  plc_pkg::vert_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output plc_pkg::vert_entry_t pop_entry,
  output logic                 not_empty
);
  import plc_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  vert_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PLC_ASSERT(a_queue_bound, count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `PLC_ASSERT(a_queue_no_pop_empty, pop |-> count != '0, "pop from empty queue")
  `PLC_ASSERT(a_queue_no_push_full, push |-> !full, "push into full queue")

endmodule

// ===== design/plc_back.sv =====
// Back end: vertex store, edge walk, crossing divider and interpolation.
`include "assert_macros.svh"

module plc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  plc_pkg::vert_entry_t q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   ox,
  output logic signed [31:0]   oy,
  output logic signed [31:0]   oz,
  output logic                 vertex_valid,
  output logic [1:0]           clip_status,
  output logic                 overflowed,
  output logic                 end_of_run
);
  import plc_pkg::*;

  localparam int REM_W     = DIST_W + 1;
  localparam int DIV_STEPS = COORD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int MULP_W    = COORD_W + FRAC_W;

  typedef enum logic [10:0] {
    B_LOAD   = 11'b00000000001,
    B_START  = 11'b00000000010,
    B_READ   = 11'b00000000100,
    B_EVAL   = 11'b00000001000,
    B_DIV    = 11'b00000010000,
    B_MUL    = 11'b00000100000,
    B_ACC    = 11'b00001000000,
    B_EMIT_X = 11'b00010000000,
    B_EMIT_V = 11'b00100000000,
    B_NEXT   = 11'b01000000000,
    B_EMPTY  = 11'b10000000000
  } back_state_t;

  back_state_t state;

  logic [COORD_W-1:0] mem_x [MAX_VERTS];
  logic [COORD_W-1:0] mem_y [MAX_VERTS];
  logic [COORD_W-1:0] mem_z [MAX_VERTS];
  logic [DIST_W-1:0]  mem_d [MAX_VERTS];

  logic [COORD_W-1:0] rd_ax, rd_ay, rd_az, rd_bx, rd_by, rd_bz;
  logic [DIST_W-1:0]  rd_ad, rd_bd;

  logic [CNT_W-1:0]     cnt;
  logic                 ovf, any_in, any_out;
  logic [MAX_VERTS-1:0] side_in;
  logic [IDX_W-1:0]     idx, prev;
  logic [REM_W-1:0]     rem;
  logic [DIST_W-1:0]    den;
  logic [FRAC_W-1:0]    t;
  logic [DCNT_W-1:0]    dcnt;
  logic [1:0]           k;
  logic [MULP_W-1:0]    prod_t;
  logic                 neg, mh;
  logic [COORD_W-1:0]   cross_x, cross_y, cross_z;

  logic                 store_ok, out_free, emit, na, nb, later, last_edge;
  logic [DIST_W-1:0]    abs_sa, abs_diff;
  logic [DIST_W:0]      diff, diff_mag;
  logic [REM_W-1:0]     rem2;
  logic [COORD_W-1:0]   a_k, b_k;
  logic [COORD_W:0]     dlt, mag;
  logic [COORD_W+1:0]   off, base, res;
  logic [MAX_VERTS-1:0] later_mask;

  assign store_ok = (cnt < CNT_W'(MAX_VERTS));
  assign q_pop    = (state == B_LOAD) & q_valid;
  assign out_free = ~out_valid | ~out_stall;
  assign emit     = out_free & ((state == B_EMIT_X) | (state == B_EMIT_V) | (state == B_EMPTY));

  assign na       = rd_ad[DIST_W-1];
  assign nb       = rd_bd[DIST_W-1];
  assign abs_sa   = na ? (~rd_ad + 1'b1) : rd_ad;
  assign diff     = {rd_ad[DIST_W-1], rd_ad} - {rd_bd[DIST_W-1], rd_bd};
  assign diff_mag = diff[DIST_W] ? (~diff + 1'b1) : diff;
  assign abs_diff = diff_mag[DIST_W-1:0];
  assign rem2     = {rem[REM_W-2:0], 1'b0};

  always_comb begin
    case (k)
      2'd0:    begin a_k = rd_ax; b_k = rd_bx; end
      2'd1:    begin a_k = rd_ay; b_k = rd_by; end
      default: begin a_k = rd_az; b_k = rd_bz; end
    endcase
  end

  assign dlt  = {b_k[COORD_W-1], b_k} - {a_k[COORD_W-1], a_k};
  assign mag  = dlt[COORD_W] ? (~dlt + 1'b1) : dlt;
  assign off  = {1'b0, (mh ? t : FRAC_W'(0))} + {1'b0, prod_t[MULP_W-1:COORD_W]};
  assign base = {{2{a_k[COORD_W-1]}}, a_k};
  assign res  = neg ? (base - off) : (base + off);

  // An edge j emits when either end is inside; look for any later one.
  always_comb begin
    for (int j = 0; j < MAX_VERTS; j++) begin
      if (j != 0) begin
        later_mask[j] = (side_in[j] | side_in[j-1]) & (CNT_W'(j) > CNT_W'(idx))
                        & (CNT_W'(j) < cnt);
      end else begin
        later_mask[j] = 1'b0;
      end
    end
  end
  assign later     = |later_mask;
  assign last_edge = ((CNT_W'(idx) + CNT_W'(1)) == cnt);

  always_ff @(posedge clk) begin
    if (q_pop && store_ok) begin
      mem_x[cnt[IDX_W-1:0]] <= q_entry.x;
      mem_y[cnt[IDX_W-1:0]] <= q_entry.y;
      mem_z[cnt[IDX_W-1:0]] <= q_entry.z;
      mem_d[cnt[IDX_W-1:0]] <= q_entry.sdist;
    end
    rd_ax <= mem_x[prev];
    rd_ay <= mem_y[prev];
    rd_az <= mem_z[prev];
    rd_ad <= mem_d[prev];
    rd_bx <= mem_x[idx];
    rd_by <= mem_y[idx];
    rd_bz <= mem_z[idx];
    rd_bd <= mem_d[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      any_in    <= 1'b0;
      any_out   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_LOAD: begin
          if (q_valid) begin
            if (store_ok) begin
              side_in[cnt[IDX_W-1:0]] <= ~q_entry.sdist[DIST_W-1];
              any_in  <= any_in | ~q_entry.sdist[DIST_W-1];
              any_out <= any_out | q_entry.sdist[DIST_W-1];
              cnt     <= cnt + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (q_entry.last) begin
              state <= B_START;
            end
          end
        end
        B_START: begin
          prev  <= IDX_W'(cnt - 1'b1);
          idx   <= '0;
          state <= any_in ? B_READ : B_EMPTY;
        end
        B_READ: state <= B_EVAL;
        B_EVAL: begin
          k <= 2'd0;
          if (!na && !nb) begin
            state <= B_EMIT_V;
          end else if (na && nb) begin
            state <= B_NEXT;
          end else begin
            den <= abs_diff;
            if (abs_sa >= abs_diff) begin
              t     <= FRAC_W'(1) << COORD_W;
              state <= B_MUL;
            end else begin
              rem   <= REM_W'(abs_sa);
              t     <= '0;
              dcnt  <= '0;
              state <= B_DIV;
            end
          end
        end
        B_DIV: begin
          if (rem2 >= REM_W'(den)) begin
            rem <= rem2 - REM_W'(den);
            t   <= {t[FRAC_W-2:0], 1'b1};
          end else begin
            rem <= rem2;
            t   <= {t[FRAC_W-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_STEPS - 1)) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_t <= mag[COORD_W-1:0] * t;
          neg    <= dlt[COORD_W];
          mh     <= mag[COORD_W];
          state  <= B_ACC;
        end
        B_ACC: begin
          case (k)
            2'd0:    cross_x <= res[COORD_W-1:0];
            2'd1:    cross_y <= res[COORD_W-1:0];
            default: cross_z <= res[COORD_W-1:0];
          endcase
          k     <= k + 2'd1;
          state <= (k == 2'd2) ? B_EMIT_X : B_MUL;
        end
        B_EMIT_X: begin
          if (out_free) begin
            ox           <= cross_x;
            oy           <= cross_y;
            oz           <= cross_z;
            vertex_valid <= 1'b1;
            clip_status  <= any_out ? STATUS_CLIPPED : STATUS_ORIGINAL;
            overflowed   <= ovf;
            end_of_run   <= nb & ~later;
            state        <= nb ? B_NEXT : B_EMIT_V;
          end
        end
        B_EMIT_V: begin
          if (out_free) begin
            ox           <= rd_bx;
            oy           <= rd_by;
            oz           <= rd_bz;
            vertex_valid <= 1'b1;
            clip_status  <= any_out ? STATUS_CLIPPED : STATUS_ORIGINAL;
            overflowed   <= ovf;
            end_of_run   <= ~later;
            state        <= B_NEXT;
          end
        end
        B_NEXT: begin
          if (last_edge) begin
            cnt     <= '0;
            ovf     <= 1'b0;
            any_in  <= 1'b0;
            any_out <= 1'b0;
            state   <= B_LOAD;
          end else begin
            prev  <= idx;
            idx   <= idx + 1'b1;
            state <= B_READ;
          end
        end
        B_EMPTY: begin
          if (out_free) begin
            ox           <= '0;
            oy           <= '0;
            oz           <= '0;
            vertex_valid <= 1'b0;
            clip_status  <= STATUS_VANISHED;
            overflowed   <= ovf;
            end_of_run   <= 1'b1;
            cnt          <= '0;
            ovf          <= 1'b0;
            any_in       <= 1'b0;
            any_out      <= 1'b0;
            state        <= B_LOAD;
          end
        end
        default: state <= B_LOAD;
      endcase
    end
  end

  `PLC_ASSERT(a_walk_range, (state == B_EVAL) |-> (CNT_W'(idx) < cnt), "index past count")
  `PLC_ASSERT(a_empty_beat, (out_valid && !vertex_valid) |-> end_of_run, "bad empty beat")
  `PLC_ASSERT_NEXT(a_div_done, state == B_DIV && dcnt == DCNT_W'(31), state == B_MUL, "div hung")

endmodule
